// File: rtl/rational_arithmetic_unit_defines.svh
// Assertion macros used by the rational arithmetic unit top level.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define RAU_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RAU_ASSERT_IMP(lbl, ante, cons, msg)
`define RAU_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/rau_pkg.sv
// Package with the request and response types and the codes of the rational arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;

   localparam int NUM_BITS = 32;
   localparam int DEN_BITS = 31;

   localparam logic [2:0] KIND_ADD = 3'd0;
   localparam logic [2:0] KIND_SUB = 3'd1;
   localparam logic [2:0] KIND_MUL = 3'd2;
   localparam logic [2:0] KIND_DIV = 3'd3;
   localparam logic [2:0] KIND_EQ  = 3'd4;
   localparam logic [2:0] KIND_GT  = 3'd5;
   localparam logic [2:0] KIND_LT  = 3'd6;
   localparam logic [2:0] KIND_NOP = 3'd7;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_DIVZ = 2'd1;
   localparam logic [1:0] STATUS_OVF  = 2'd2;

   typedef struct packed {
      logic [2:0]                 kind;
      logic signed [NUM_BITS-1:0] left_numerator;
      logic [DEN_BITS-1:0]        left_denominator;
      logic signed [NUM_BITS-1:0] right_numerator;
      logic [DEN_BITS-1:0]        right_denominator;
   } req_type;

   typedef struct packed {
      logic signed [NUM_BITS-1:0] result_numerator;
      logic [DEN_BITS-1:0]        result_denominator;
      logic                       compare_true;
      logic [1:0]                 status;
   } rsp_type;

endpackage
`default_nettype wire

// File: rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit with its sequencer.
//
// A request carries an operation kind and two rationals; each request yields
// exactly one response on the rsp_ channel (valid/ready).
// Cross products are formed one per cycle on a single shared multiplier, the
// raw result is reduced by a binary gcd unit that takes one step per cycle,
// and both parts are then divided by the gcd on one restoring divider, one
// quotient bit per cycle, numerator first and denominator second.
// Requests settled early (the NOP kind, a zero denominator, division by zero)
// go from idle straight to the finish state; compares are settled in the prep
// state after the cross products; arithmetic passes through the gcd and both
// divisions, unless the raw numerator is zero, which settles in the prep state.
// The block handles one request at a time; req_ready is high only while the
// sequencer is idle, so it takes no new request until the last one is finished.
// A finished response sits in an output register; the next request may be
// accepted while it waits, and that request holds in its last state until
// the receiver takes the earlier response.
// Reset empties the output register and returns the sequencer to idle.
`timescale 1ns / 1ps
`default_nettype none
`include "rational_arithmetic_unit_defines.svh"
module rational_arithmetic_unit #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire rau_pkg::req_type req,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rau_pkg::rsp_type     rsp
);
   import rau_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int PW = 2 * W;
   localparam int MW = PW - 1;
   localparam logic [MW-1:0] NUM_MAX = MW'(1) << (W - 1);
   localparam logic [MW-1:0] DEN_MAX = NUM_MAX - MW'(1);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b00000001,
      ST_MUL  = 8'b00000010,
      ST_PREP = 8'b00000100,
      ST_GCD  = 8'b00001000,
      ST_DIVN = 8'b00010000,
      ST_DIVD = 8'b00100000,
      ST_CHK  = 8'b01000000,
      ST_FIN  = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [2:0] kind_ff, kind_in;
   logic signed [W-1:0] ln_ff, ln_in, ld_ff, ld_in, rn_ff, rn_in, rd_ff, rd_in;
   logic signed [PW-1:0] pa_ff, pa_in, pb_ff, pb_in, pc_ff, pc_in;
   logic [MW-1:0] mag_ff, mag_in, dmag_ff, dmag_in, magq_ff, magq_in;
   logic neg_ff, neg_in;
   logic gcd_start_ff, gcd_start_in, div_start_ff, div_start_in;
   rsp_type res_ff, res_in, rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic signed [W-1:0] mul_a, mul_b;
   logic signed [PW-1:0] mul_p;
   logic gcd_done, div_done;
   logic [MW-1:0] gcd_g, div_n, div_q;
   logic signed [PW:0] sum_w;
   logic signed [PW-1:0] num_w;
   logic [NUM_BITS-1:0] mag32;
   logic ovf;

   rau_mult #(.W(W)) u_mult (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   rau_gcd #(.MW(MW)) u_gcd (
      .clock (clock),
      .reset (reset),
      .start (gcd_start_ff),
      .x     (mag_ff),
      .y     (dmag_ff),
      .done  (gcd_done),
      .g     (gcd_g)
   );

   assign div_n = (state_ff == ST_DIVN) ? mag_ff : dmag_ff;

   rau_div #(.MW(MW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .n     (div_n),
      .d     (gcd_g),
      .done  (div_done),
      .q     (div_q)
   );

   always_comb begin
      mul_a = ln_ff;
      mul_b = rd_ff;
      case (cnt_ff)
         2'd0: begin
            mul_a = ln_ff;
            mul_b = (kind_ff == KIND_MUL) ? rn_ff : rd_ff;
         end
         2'd1: begin
            mul_a = rn_ff;
            mul_b = ld_ff;
         end
         default: begin
            mul_a = ld_ff;
            mul_b = (kind_ff == KIND_DIV) ? rn_ff : rd_ff;
         end
      endcase
   end

   always_comb begin
      case (kind_ff)
         KIND_ADD: sum_w = (PW+1)'(pa_ff) + (PW+1)'(pb_ff);
         KIND_SUB: sum_w = (PW+1)'(pa_ff) - (PW+1)'(pb_ff);
         default:  sum_w = (PW+1)'(pa_ff);
      endcase
      num_w = sum_w[PW-1:0];
      ovf   = (div_q > DEN_MAX) || (magq_ff > NUM_MAX) || (!neg_ff && magq_ff == NUM_MAX);
      mag32 = NUM_BITS'(magq_ff);
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      kind_in      = kind_ff;
      ln_in        = ln_ff;
      ld_in        = ld_ff;
      rn_in        = rn_ff;
      rd_in        = rd_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      pc_in        = pc_ff;
      mag_in       = mag_ff;
      dmag_in      = dmag_ff;
      magq_in      = magq_ff;
      neg_in       = neg_ff;
      gcd_start_in = 1'b0;
      div_start_in = 1'b0;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in = req.kind;
               ln_in   = req.left_numerator[W-1:0];
               ld_in   = {1'b0, req.left_denominator[W-2:0]};
               rn_in   = req.right_numerator[W-1:0];
               rd_in   = {1'b0, req.right_denominator[W-2:0]};
               cnt_in  = 2'd0;
               res_in  = '{result_numerator: '0, result_denominator: DEN_BITS'(1),
                           compare_true: 1'b0, status: STATUS_OK};
               if (req.kind == KIND_NOP) begin
                  state_in = ST_FIN;
               end else if (req.left_denominator[W-2:0] == '0 ||
                            req.right_denominator[W-2:0] == '0 ||
                            (req.kind == KIND_DIV && req.right_numerator[W-1:0] == '0)) begin
                  res_in.status = STATUS_DIVZ;
                  state_in      = ST_FIN;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cnt_in = cnt_ff + 2'd1;
            case (cnt_ff)
               2'd1: pa_in = mul_p;
               2'd2: pb_in = mul_p;
               2'd3: pc_in = mul_p;
               default: ;
            endcase
            if (cnt_ff == 2'd3) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            neg_in  = num_w[PW-1] ^ pc_ff[PW-1];
            mag_in  = num_w[PW-1] ? MW'(-num_w) : MW'(num_w);
            dmag_in = pc_ff[PW-1] ? MW'(-pc_ff) : MW'(pc_ff);
            case (kind_ff)
               KIND_EQ: begin
                  res_in.compare_true = (pa_ff == pb_ff);
                  state_in            = ST_FIN;
               end
               KIND_GT: begin
                  res_in.compare_true = (pa_ff > pb_ff);
                  state_in            = ST_FIN;
               end
               KIND_LT: begin
                  res_in.compare_true = (pa_ff < pb_ff);
                  state_in            = ST_FIN;
               end
               default: begin
                  if (num_w == '0) begin
                     state_in = ST_FIN;
                  end else begin
                     gcd_start_in = 1'b1;
                     state_in     = ST_GCD;
                  end
               end
            endcase
         end
         ST_GCD: begin
            if (gcd_done) begin
               div_start_in = 1'b1;
               state_in     = ST_DIVN;
            end
         end
         ST_DIVN: begin
            if (div_done) begin
               magq_in      = div_q;
               div_start_in = 1'b1;
               state_in     = ST_DIVD;
            end
         end
         ST_DIVD: begin
            if (div_done) begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (ovf) begin
               res_in.status = STATUS_OVF;
            end else begin
               res_in.result_numerator   = neg_ff ? -mag32 : mag32;
               res_in.result_denominator = DEN_BITS'(div_q);
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      kind_ff <= kind_in;
      ln_ff   <= ln_in;
      ld_ff   <= ld_in;
      rn_ff   <= rn_in;
      rd_ff   <= rd_in;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      pc_ff   <= pc_in;
      mag_ff  <= mag_in;
      dmag_ff <= dmag_in;
      magq_ff <= magq_in;
      neg_ff  <= neg_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         gcd_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gcd_start_ff <= gcd_start_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `RAU_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, state_ff != ST_IDLE, "sequencer stayed idle after a request")
   `RAU_ASSERT_IMP(a_fail_clean, rsp_valid && rsp.status != STATUS_OK, rsp.result_numerator == '0 && rsp.result_denominator == DEN_BITS'(1) && !rsp.compare_true, "failed response carries a value")
   `RAU_ASSERT_IMP(a_cmp_clean, rsp_valid && rsp.compare_true, rsp.status == STATUS_OK && rsp.result_numerator == '0, "compare response carries a value")
   `RAU_ASSERT_IMP(a_den_nonzero, rsp_valid, rsp.result_denominator != '0, "response denominator is zero")

endmodule
`default_nettype wire

// File: rtl/rau_mult.sv
// Registered signed multiplier shared by all cross products.
`timescale 1ns / 1ps
`default_nettype none
module rau_mult #(
   parameter int W = 32
) (
   input  wire logic                  clock,
   input  wire logic signed [W-1:0]   a,
   input  wire logic signed [W-1:0]   b,
   output logic signed [2*W-1:0]      p
);

   logic signed [2*W-1:0] p_ff;

   always_ff @(posedge clock) begin
      p_ff <= a * b;
   end

   assign p = p_ff;

endmodule
`default_nettype wire

// File: rtl/rau_gcd.sv
// Iterative binary gcd unit, one step per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rau_gcd #(
   parameter int MW = 63
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [MW-1:0] x,
   input  wire logic [MW-1:0] y,
   output logic               done,
   output logic [MW-1:0]      g
);

   localparam int KW = $clog2(MW + 1);

   logic [MW-1:0] a_ff, a_in, b_ff, b_in;
   logic [KW-1:0] k_ff, k_in;
   logic          run_ff, run_in, done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      k_in    = k_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         a_in   = x;
         b_in   = y;
         k_in   = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (a_ff == b_ff) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff > b_ff) begin
            a_in = (a_ff - b_ff) >> 1;
         end else begin
            b_in = (b_ff - a_ff) >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      k_ff <= k_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign g    = a_ff << k_ff;

endmodule
`default_nettype wire

// File: rtl/rau_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rau_div #(
   parameter int MW = 63
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [MW-1:0] n,
   input  wire logic [MW-1:0] d,
   output logic               done,
   output logic [MW-1:0]      q
);

   localparam int CW = $clog2(MW + 1);

   logic [MW-1:0] rem_ff, rem_in, q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in, done_ff, done_in;
   logic [MW:0]   trial;
   logic          ge;

   always_comb begin
      trial   = {rem_ff, q_ff[MW-1]};
      ge      = trial >= {1'b0, d};
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         q_in   = n;
         cnt_in = CW'(MW);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? MW'(trial - {1'b0, d}) : trial[MW-1:0];
         q_in   = {q_ff[MW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign q    = q_ff;

endmodule
`default_nettype wire

// File: verif/tb_rational_arithmetic_unit.sv
// Self-checking testbench of the rational arithmetic unit against an exact predictor.
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit;
   import rau_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp;

   rsp_type expected_results[$];
   int mismatch_count = 0;
   bit hold_off = 1'b0;
   bit calm = 1'b0;

   rational_arithmetic_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req(req),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
   );

   always #4 clock = ~clock;

   function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic rsp_type settle(logic signed [31:0] num, logic [30:0] den,
                                      logic cmp, logic [1:0] status);
      rsp_type r;
      r.result_numerator = num;
      r.result_denominator = den;
      r.compare_true = cmp;
      r.status = status;
      return r;
   endfunction

   function automatic rsp_type rational_result(req_type q);
      longint ln, ld, rn, rd, a, b, num, den;
      longint unsigned mag, dmag, g;
      bit neg;
      ln = longint'(q.left_numerator);
      ld = longint'({1'b0, q.left_denominator});
      rn = longint'(q.right_numerator);
      rd = longint'({1'b0, q.right_denominator});
      if (q.kind == KIND_NOP) return settle(0, 1, 0, STATUS_OK);
      if (ld == 0 || rd == 0) return settle(0, 1, 0, STATUS_DIVZ);
      if (q.kind >= KIND_EQ) begin
         a = ln * rd;
         b = rn * ld;
         return settle(0, 1, (q.kind == KIND_EQ) ? (a == b) :
                              (q.kind == KIND_GT) ? (a > b) : (a < b), STATUS_OK);
      end
      case (q.kind)
         KIND_ADD: begin num = ln * rd + rn * ld; den = ld * rd; end
         KIND_SUB: begin num = ln * rd - rn * ld; den = ld * rd; end
         KIND_MUL: begin num = ln * rn; den = ld * rd; end
         default: begin
            if (rn == 0) return settle(0, 1, 0, STATUS_DIVZ);
            num = ln * rd;
            den = ld * rn;
         end
      endcase
      neg = (num < 0) != (den < 0);
      mag = (num < 0) ? -num : num;
      dmag = (den < 0) ? -den : den;
      if (mag == 0) return settle(0, 1, 0, STATUS_OK);
      g = gcd_of(mag, dmag);
      mag = mag / g;
      dmag = dmag / g;
      if (dmag > 64'h7FFF_FFFF || mag > 64'h8000_0000 || (!neg && mag == 64'h8000_0000))
         return settle(0, 1, 0, STATUS_OVF);
      return settle(neg ? -mag : mag, dmag, 0, STATUS_OK);
   endfunction

   task automatic send_request(req_type q);
      while (!calm && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req <= q;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(rational_result(q));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response %p", rsp);
         end else begin
            rsp_type e;
            e = expected_results.pop_front();
            if (rsp !== e) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("expected %p actual %p", e, rsp);
            end
         end
      end
      rsp_ready <= !hold_off && (calm || $urandom_range(99) >= 7);
   end

   function automatic logic signed [31:0] any_numerator();
      case ($urandom_range(4))
         0: return $urandom_range(0, 20) - 10;
         1: return $urandom_range(0, 2000) - 1000;
         2: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [30:0] any_denominator();
      case ($urandom_range(5))
         0: return $urandom_range(1, 12);
         1: return $urandom_range(1, 5000);
         2: return 31'h7FFF_FFFF;
         3: return ($urandom_range(19) == 0) ? 31'd0 : 31'd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type any_request();
      req_type q;
      q.kind = $urandom_range(7);
      q.left_numerator = any_numerator();
      q.left_denominator = any_denominator();
      q.right_numerator = any_numerator();
      q.right_denominator = any_denominator();
      return q;
   endfunction

   task automatic test_directed();
      req_type q;
      for (int k = 0; k <= 7; k++) begin
         q = '{kind: k, left_numerator: 3, left_denominator: 4,
               right_numerator: -5, right_denominator: 6};
         send_request(q);
      end
      send_request('{KIND_DIV, 32'sd7, 31'd2, 32'sd0, 31'd3});
      send_request('{KIND_ADD, 32'sd1, 31'd0, 32'sd1, 31'd1});
      send_request('{KIND_GT, 32'sd1, 31'd1, 32'sd1, 31'd0});
      send_request('{KIND_MUL, 32'h8000_0000, 31'd1, 32'sd1, 31'd1});
      send_request('{KIND_MUL, 32'h8000_0000, 31'd1, -32'sd1, 31'd1});
      send_request('{KIND_ADD, 32'h7FFF_FFFF, 31'd1, 32'sd1, 31'd1});
      send_request('{KIND_ADD, 32'sd1, 31'h7FFF_FFFF, 32'sd1, 31'd2});
      send_request('{KIND_SUB, 32'sd5, 31'd7, 32'sd5, 31'd7});
      send_request('{KIND_EQ, 32'sd2, 31'd4, 32'sd1, 31'd2});
      send_request('{KIND_LT, 32'h8000_0000, 31'd1, 32'h7FFF_FFFF, 31'h7FFF_FFFF});
      send_request('{KIND_DIV, 32'h8000_0000, 31'h7FFF_FFFF, -32'sd1, 31'd1});
      send_request('{KIND_DIV, 32'sd3, 31'd5, 32'h8000_0000, 31'd1});
      send_request('{KIND_ADD, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF});
   endtask

   task automatic test_random(int count);
      repeat (count) send_request(any_request());
   endtask

   task automatic test_calm(int count);
      calm = 1'b1;
      repeat (count) send_request(any_request());
      calm = 1'b0;
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (2000) @(posedge clock);
            hold_off = 1'b0;
         end
         repeat (20) send_request(any_request());
      join
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(450);
      test_backpressure();
      test_calm(150);
      test_random(310);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #20ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule
